// ----- rtl/qau_pkg.sv -----
// shared types, constants and microprogram of the quaternion attitude update unit
package qau_pkg;

   localparam int QAU_QUAT_FRAC_BITS = 14;
   localparam int QAU_STEP_FRAC_BITS = 7;

   // degrees to radians, 30 fraction bits
   localparam logic signed [32:0] D2R_Q30 = 33'sd18740330;
   // one half at 30 fraction bits, scales q onto the update accumulator
   localparam logic signed [32:0] HALF_Q30 = 33'sd536870912;
   // global step limit, plus and minus
   localparam logic signed [41:0] WG_LIMIT = 42'sd1099511627776;

   localparam int UC_LEN = 71;
   localparam int UC_PCW = $clog2(UC_LEN);

   typedef enum logic [1:0] {A_STEP, A_Q, A_WC, A_WG} asel_type;
   typedef enum logic [1:0] {B_D2R, B_Q, B_M, B_HALF} bsel_type;
   typedef enum logic [1:0] {D_WC, D_M, D_WG, D_ACC} dst_type;
   typedef enum logic {UOP_MAC, UOP_STORE} uop_kind_type;

   typedef struct packed {
      uop_kind_type kind;
      logic         clr;
      logic         neg;
      asel_type     asel;
      logic [1:0]   aidx;
      bsel_type     bsel;
      logic [3:0]   bidx;
      dst_type      dst;
      logic [3:0]   didx;
      logic         dbl;
      logic         last;
   } uop_type;

   // shift right with rounding half away from zero
   function automatic logic signed [63:0] shr_round(input logic signed [63:0] v,
                                                    input int unsigned s);
      logic [64:0] mg;
      logic [64:0] rd;
      logic [64:0] ng;
      mg = v[63] ? (65'd0 - {v[63], v}) : {1'b0, v};
      rd = (mg + (65'd1 << (s - 1))) >> s;
      ng = 65'd0 - rd;
      if (s == 0) begin
         return v;
      end
      return v[63] ? ng[63:0] : rd[63:0];
   endfunction

   function automatic uop_type f_mac(input logic clr, input logic neg,
                                     input asel_type as, input logic [1:0] ai,
                                     input bsel_type bs, input logic [3:0] bi);
      uop_type u;
      u = '0;
      u.kind = UOP_MAC;
      u.clr  = clr;
      u.neg  = neg;
      u.asel = as;
      u.aidx = ai;
      u.bsel = bs;
      u.bidx = bi;
      return u;
   endfunction

   function automatic uop_type f_st(input dst_type d, input logic [3:0] di,
                                    input logic dbl, input logic last);
      uop_type u;
      u = '0;
      u.kind = UOP_STORE;
      u.dst  = d;
      u.didx = di;
      u.dbl  = dbl;
      u.last = last;
      return u;
   endfunction

   // rotate program: radians, matrix, global step, update accumulators
   function automatic uop_type uc_entry(input logic [UC_PCW-1:0] pc);
      uop_type u;
      unique case (pc)
         // step to radians
         7'd0:  u = f_mac(1'b1, 1'b0, A_STEP, 2'd0, B_D2R, 4'd0);
         7'd1:  u = f_st(D_WC, 4'd0, 1'b0, 1'b0);
         7'd2:  u = f_mac(1'b1, 1'b0, A_STEP, 2'd1, B_D2R, 4'd0);
         7'd3:  u = f_st(D_WC, 4'd1, 1'b0, 1'b0);
         7'd4:  u = f_mac(1'b1, 1'b0, A_STEP, 2'd2, B_D2R, 4'd0);
         7'd5:  u = f_st(D_WC, 4'd2, 1'b0, 1'b0);
         // m00
         7'd6:  u = f_mac(1'b1, 1'b0, A_Q, 2'd0, B_Q, 4'd0);
         7'd7:  u = f_mac(1'b0, 1'b0, A_Q, 2'd1, B_Q, 4'd1);
         7'd8:  u = f_mac(1'b0, 1'b1, A_Q, 2'd2, B_Q, 4'd2);
         7'd9:  u = f_mac(1'b0, 1'b1, A_Q, 2'd3, B_Q, 4'd3);
         7'd10: u = f_st(D_M, 4'd0, 1'b0, 1'b0);
         // m01
         7'd11: u = f_mac(1'b1, 1'b0, A_Q, 2'd1, B_Q, 4'd2);
         7'd12: u = f_mac(1'b0, 1'b1, A_Q, 2'd0, B_Q, 4'd3);
         7'd13: u = f_st(D_M, 4'd1, 1'b1, 1'b0);
         // m02
         7'd14: u = f_mac(1'b1, 1'b0, A_Q, 2'd1, B_Q, 4'd3);
         7'd15: u = f_mac(1'b0, 1'b0, A_Q, 2'd0, B_Q, 4'd2);
         7'd16: u = f_st(D_M, 4'd2, 1'b1, 1'b0);
         // m10
         7'd17: u = f_mac(1'b1, 1'b0, A_Q, 2'd1, B_Q, 4'd2);
         7'd18: u = f_mac(1'b0, 1'b0, A_Q, 2'd0, B_Q, 4'd3);
         7'd19: u = f_st(D_M, 4'd3, 1'b1, 1'b0);
         // m11
         7'd20: u = f_mac(1'b1, 1'b0, A_Q, 2'd0, B_Q, 4'd0);
         7'd21: u = f_mac(1'b0, 1'b1, A_Q, 2'd1, B_Q, 4'd1);
         7'd22: u = f_mac(1'b0, 1'b0, A_Q, 2'd2, B_Q, 4'd2);
         7'd23: u = f_mac(1'b0, 1'b1, A_Q, 2'd3, B_Q, 4'd3);
         7'd24: u = f_st(D_M, 4'd4, 1'b0, 1'b0);
         // m12
         7'd25: u = f_mac(1'b1, 1'b0, A_Q, 2'd2, B_Q, 4'd3);
         7'd26: u = f_mac(1'b0, 1'b1, A_Q, 2'd0, B_Q, 4'd1);
         7'd27: u = f_st(D_M, 4'd5, 1'b1, 1'b0);
         // m20
         7'd28: u = f_mac(1'b1, 1'b0, A_Q, 2'd1, B_Q, 4'd3);
         7'd29: u = f_mac(1'b0, 1'b1, A_Q, 2'd0, B_Q, 4'd2);
         7'd30: u = f_st(D_M, 4'd6, 1'b1, 1'b0);
         // m21
         7'd31: u = f_mac(1'b1, 1'b0, A_Q, 2'd2, B_Q, 4'd3);
         7'd32: u = f_mac(1'b0, 1'b0, A_Q, 2'd0, B_Q, 4'd1);
         7'd33: u = f_st(D_M, 4'd7, 1'b1, 1'b0);
         // m22
         7'd34: u = f_mac(1'b1, 1'b0, A_Q, 2'd0, B_Q, 4'd0);
         7'd35: u = f_mac(1'b0, 1'b1, A_Q, 2'd1, B_Q, 4'd1);
         7'd36: u = f_mac(1'b0, 1'b1, A_Q, 2'd2, B_Q, 4'd2);
         7'd37: u = f_mac(1'b0, 1'b0, A_Q, 2'd3, B_Q, 4'd3);
         7'd38: u = f_st(D_M, 4'd8, 1'b0, 1'b0);
         // global step, matrix rows times body step
         7'd39: u = f_mac(1'b1, 1'b0, A_WC, 2'd0, B_M, 4'd0);
         7'd40: u = f_mac(1'b0, 1'b0, A_WC, 2'd1, B_M, 4'd1);
         7'd41: u = f_mac(1'b0, 1'b0, A_WC, 2'd2, B_M, 4'd2);
         7'd42: u = f_st(D_WG, 4'd0, 1'b0, 1'b0);
         7'd43: u = f_mac(1'b1, 1'b0, A_WC, 2'd0, B_M, 4'd3);
         7'd44: u = f_mac(1'b0, 1'b0, A_WC, 2'd1, B_M, 4'd4);
         7'd45: u = f_mac(1'b0, 1'b0, A_WC, 2'd2, B_M, 4'd5);
         7'd46: u = f_st(D_WG, 4'd1, 1'b0, 1'b0);
         7'd47: u = f_mac(1'b1, 1'b0, A_WC, 2'd0, B_M, 4'd6);
         7'd48: u = f_mac(1'b0, 1'b0, A_WC, 2'd1, B_M, 4'd7);
         7'd49: u = f_mac(1'b0, 1'b0, A_WC, 2'd2, B_M, 4'd8);
         7'd50: u = f_st(D_WG, 4'd2, 1'b0, 1'b0);
         // acc0
         7'd51: u = f_mac(1'b1, 1'b0, A_Q, 2'd0, B_HALF, 4'd0);
         7'd52: u = f_mac(1'b0, 1'b1, A_WG, 2'd0, B_Q, 4'd1);
         7'd53: u = f_mac(1'b0, 1'b1, A_WG, 2'd1, B_Q, 4'd2);
         7'd54: u = f_mac(1'b0, 1'b1, A_WG, 2'd2, B_Q, 4'd3);
         7'd55: u = f_st(D_ACC, 4'd0, 1'b0, 1'b0);
         // acc1
         7'd56: u = f_mac(1'b1, 1'b0, A_Q, 2'd1, B_HALF, 4'd0);
         7'd57: u = f_mac(1'b0, 1'b0, A_WG, 2'd0, B_Q, 4'd0);
         7'd58: u = f_mac(1'b0, 1'b1, A_WG, 2'd2, B_Q, 4'd2);
         7'd59: u = f_mac(1'b0, 1'b0, A_WG, 2'd1, B_Q, 4'd3);
         7'd60: u = f_st(D_ACC, 4'd1, 1'b0, 1'b0);
         // acc2
         7'd61: u = f_mac(1'b1, 1'b0, A_Q, 2'd2, B_HALF, 4'd0);
         7'd62: u = f_mac(1'b0, 1'b0, A_WG, 2'd1, B_Q, 4'd0);
         7'd63: u = f_mac(1'b0, 1'b0, A_WG, 2'd2, B_Q, 4'd1);
         7'd64: u = f_mac(1'b0, 1'b1, A_WG, 2'd0, B_Q, 4'd3);
         7'd65: u = f_st(D_ACC, 4'd2, 1'b0, 1'b0);
         // acc3
         7'd66: u = f_mac(1'b1, 1'b0, A_Q, 2'd3, B_HALF, 4'd0);
         7'd67: u = f_mac(1'b0, 1'b0, A_WG, 2'd2, B_Q, 4'd0);
         7'd68: u = f_mac(1'b0, 1'b1, A_WG, 2'd1, B_Q, 4'd1);
         7'd69: u = f_mac(1'b0, 1'b0, A_WG, 2'd0, B_Q, 4'd2);
         7'd70: u = f_st(D_ACC, 4'd3, 1'b0, 1'b1);
         default: u = f_st(D_ACC, 4'd3, 1'b0, 1'b1);
      endcase
      return u;
   endfunction

endpackage

// ----- rtl/quaternion_attitude_update_unit.sv -----
// quaternion attitude update unit: first-order integration with renormalization
//
// one request beat carries a mode flag in tuser and seven 16-bit fields in tdata;
// each request beat yields exactly one response beat with the stored quaternion
// mode 1 loads the quaternion as given and goes straight to S_DONE, which fills
// the response register and returns to idle once that register is free
// mode 0 rotates by the body-frame steps; a microprogram on one shared 33x33
// multiplier builds radians, the rotation matrix, the global step and the
// update in low, high and add phases per multiply (52 multiplies, 19 stores)
// renormalization: a right shift of 0 to about 27 bits, one bit at a time, the
// sum of four squares on the same multiplier, a bit-pair square root, then a
// restoring division per component with QUAT_FRAC_BITS + 2 quotient bits
// req_tready is high only while the unit is idle; one item is in flight at a time
// the response register holds the result until rsp_tready; a stalled receiver
// holds the finished item in its last state and blocks the next request
// an all-zero quaternion stays all zero; results saturate to 16 bits
// reset (synchronous) sets the identity quaternion and empties the response
module quaternion_attitude_update_unit
   import qau_pkg::*;
#(
   parameter int QUAT_FRAC_BITS = QAU_QUAT_FRAC_BITS,
   parameter int STEP_FRAC_BITS = QAU_STEP_FRAC_BITS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // step_roll, step_pitch, step_yaw, load_w, load_x, load_y, load_z
   input  logic [111:0] req_tdata,
   // mode
   input  logic [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // quat_w, quat_x, quat_y, quat_z
   output logic [63:0]  rsp_tdata
);

   localparam int QF  = QUAT_FRAC_BITS;
   localparam int SF  = STEP_FRAC_BITS;
   localparam int WCW = 41 - SF;        // body step in radians, 28 fraction bits
   localparam int MW  = 35 - QF;        // rounded matrix entry
   localparam int WGW = 42;             // global step, limited to +-2^40
   localparam int K   = QF + 2;         // quotient bits of the final divide
   localparam int NW  = QF + 32;        // dividend bits
   localparam int RW  = 33;             // partial remainder bits
   localparam int KCW = $clog2(K);
   localparam logic signed [15:0] Q_ONE = (QF >= 15) ? 16'sd32767 : 16'(1 << QF);

   typedef enum logic [3:0] {
      S_IDLE, S_PROG, S_SHIFT, S_SQ, S_SQRT, S_DIVLD, S_DIV, S_DIVST, S_DONE
   } state_type;

   typedef enum logic [1:0] {MPH_LO, MPH_HI, MPH_ADD} mph_type;

   state_type               state_ff;
   mph_type                 ph_ff;
   logic [UC_PCW-1:0]       pc_ff;
   logic signed [15:0]      q_ff [4];
   logic signed [15:0]      step_ff [3];
   logic signed [WCW-1:0]   wc_ff [3];
   logic signed [MW-1:0]    m_ff [9];
   logic signed [WGW-1:0]   wg_ff [3];
   logic [63:0]             mag_ff [4];
   logic [3:0]              sign_ff;
   logic [3:0]              rbit_ff;
   logic [30:0]             a_ff [4];
   logic [1:0]              sq_idx_ff;
   logic [63:0]             prod_ff;
   logic signed [63:0]      acc_ff;
   logic [63:0]             sr_x_ff;
   logic [63:0]             sr_r_ff;
   logic [63:0]             sr_bit_ff;
   logic [31:0]             n_ff;
   logic [RW-1:0]           rem_ff;
   logic [K-1:0]            nq_ff;
   logic [KCW-1:0]          div_cnt_ff;
   logic [1:0]              div_idx_ff;
   logic                    rsp_tvalid_ff;
   logic [63:0]             rsp_tdata_ff;

   uop_type                 uop;
   logic signed [63:0]      op_a;
   logic signed [32:0]      op_b;
   logic signed [32:0]      mul_a;
   logic signed [65:0]      mul_p;
   logic                    mac_neg;
   logic                    mac_clr;
   logic signed [63:0]      add_lo;
   logic signed [63:0]      add_hi;
   logic signed [63:0]      acc_lo_sum;
   logic signed [63:0]      acc_hi_sum;
   logic signed [63:0]      st_wc;
   logic signed [63:0]      m_src;
   logic signed [63:0]      st_m;
   logic signed [63:0]      wg_r;
   logic signed [WGW-1:0]   st_wg;
   logic                    big;
   logic [63:0]             sq_t;
   logic                    sq_ge;
   logic [63:0]             sq_r_next;
   logic [NW-1:0]           div_num;
   logic [RW-1:0]           div_trial;
   logic                    div_ge;
   logic [31:0]             quot_x;
   logic signed [15:0]      div_res;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   assign uop = uc_entry(pc_ff);

   // operand select for the shared multiplier
   always_comb begin
      if (state_ff == S_SQ) begin
         op_a = signed'({33'd0, a_ff[sq_idx_ff]});
         op_b = signed'({2'b00, a_ff[sq_idx_ff]});
      end else begin
         unique case (uop.asel)
            A_STEP:  op_a = 64'(step_ff[uop.aidx]);
            A_Q:     op_a = 64'(q_ff[uop.aidx]);
            A_WC:    op_a = 64'(wc_ff[uop.aidx]);
            A_WG:    op_a = 64'(wg_ff[uop.aidx]);
            default: op_a = '0;
         endcase
         unique case (uop.bsel)
            B_D2R:   op_b = D2R_Q30;
            B_Q:     op_b = 33'(q_ff[uop.bidx[1:0]]);
            B_M:     op_b = 33'(m_ff[uop.bidx]);
            B_HALF:  op_b = HALF_Q30;
            default: op_b = '0;
         endcase
      end
   end

   // low word unsigned first, then signed high word
   assign mul_a = (ph_ff == MPH_LO) ? signed'({1'b0, op_a[31:0]}) :
                                      signed'({op_a[63], op_a[63:32]});
   assign mul_p = mul_a * op_b;

   assign mac_neg    = (state_ff == S_SQ) ? 1'b0 : uop.neg;
   assign mac_clr    = (state_ff == S_SQ) ? (sq_idx_ff == 2'd0) : uop.clr;
   assign add_lo     = mac_neg ? -signed'(prod_ff) : signed'(prod_ff);
   assign add_hi     = mac_neg ? -signed'({prod_ff[31:0], 32'd0}) :
                                 signed'({prod_ff[31:0], 32'd0});
   assign acc_lo_sum = (mac_clr ? 64'sd0 : acc_ff) + add_lo;
   assign acc_hi_sum = acc_ff + add_hi;

   // store path rounding
   always_comb begin
      st_wc = shr_round(acc_ff, SF + 2);
      m_src = uop.dbl ? (acc_ff <<< 1) : acc_ff;
      st_m  = shr_round(m_src, QF);
      wg_r  = shr_round(acc_ff, QF);
      if (wg_r > 64'(WG_LIMIT)) begin
         st_wg = WG_LIMIT;
      end else if (wg_r < -64'(WG_LIMIT)) begin
         st_wg = -WG_LIMIT;
      end else begin
         st_wg = wg_r[WGW-1:0];
      end
   end

   // normalizing shift: any magnitude at or above 2^30 shifts all by one
   always_comb begin
      big = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (mag_ff[i][63:30] != '0) begin
            big = 1'b1;
         end
      end
   end

   // square root step
   assign sq_t      = sr_r_ff + sr_bit_ff;
   assign sq_ge     = (sr_x_ff >= sq_t);
   assign sq_r_next = sq_ge ? ((sr_r_ff >> 1) + sr_bit_ff) : (sr_r_ff >> 1);

   // restoring divide step
   assign div_num   = ({(NW-31)'(0), a_ff[div_idx_ff]} << QF) + NW'(n_ff >> 1);
   assign div_trial = {rem_ff[RW-2:0], nq_ff[K-1]};
   assign div_ge    = (div_trial >= RW'(n_ff));

   // saturate the quotient and restore the sign
   always_comb begin
      quot_x = 32'(nq_ff);
      if (n_ff == '0) begin
         div_res = '0;
      end else if (sign_ff[div_idx_ff]) begin
         div_res = (quot_x > 32'd32768) ? -16'sd32768 : 16'(32'd0 - quot_x);
      end else begin
         div_res = (quot_x > 32'd32767) ? 16'sd32767 : 16'(quot_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ph_ff         <= MPH_LO;
         pc_ff         <= '0;
         rsp_tvalid_ff <= 1'b0;
         q_ff[0]       <= Q_ONE;
         q_ff[1]       <= '0;
         q_ff[2]       <= '0;
         q_ff[3]       <= '0;
      end else begin
         // a finishing item refills the response register in the same cycle
         if (rsp_tvalid_ff && rsp_tready && state_ff != S_DONE) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  step_ff[0] <= req_tdata[15:0];
                  step_ff[1] <= req_tdata[31:16];
                  step_ff[2] <= req_tdata[47:32];
                  if (req_tuser[0]) begin
                     q_ff[0]  <= req_tdata[63:48];
                     q_ff[1]  <= req_tdata[79:64];
                     q_ff[2]  <= req_tdata[95:80];
                     q_ff[3]  <= req_tdata[111:96];
                     state_ff <= S_DONE;
                  end else begin
                     pc_ff    <= '0;
                     ph_ff    <= MPH_LO;
                     state_ff <= S_PROG;
                  end
               end
            end
            S_PROG: begin
               if (uop.kind == UOP_STORE) begin
                  unique case (uop.dst)
                     D_WC: wc_ff[uop.didx[1:0]] <= st_wc[WCW-1:0];
                     D_M:  m_ff[uop.didx]       <= st_m[MW-1:0];
                     D_WG: wg_ff[uop.didx[1:0]] <= st_wg;
                     D_ACC: begin
                        mag_ff[uop.didx[1:0]]  <= acc_ff[63] ? (64'd0 - acc_ff) : acc_ff;
                        sign_ff[uop.didx[1:0]] <= acc_ff[63];
                        rbit_ff[uop.didx[1:0]] <= 1'b0;
                     end
                     default: ;
                  endcase
                  if (uop.last) begin
                     state_ff <= S_SHIFT;
                  end else begin
                     pc_ff <= pc_ff + 1'b1;
                  end
               end else begin
                  unique case (ph_ff)
                     MPH_LO: begin
                        prod_ff <= mul_p[63:0];
                        ph_ff   <= MPH_HI;
                     end
                     MPH_HI: begin
                        acc_ff  <= acc_lo_sum;
                        prod_ff <= mul_p[63:0];
                        ph_ff   <= MPH_ADD;
                     end
                     default: begin
                        acc_ff <= acc_hi_sum;
                        ph_ff  <= MPH_LO;
                        pc_ff  <= pc_ff + 1'b1;
                     end
                  endcase
               end
            end
            S_SHIFT: begin
               if (big) begin
                  for (int i = 0; i < 4; i++) begin
                     mag_ff[i]  <= mag_ff[i] >> 1;
                     rbit_ff[i] <= mag_ff[i][0];
                  end
               end else begin
                  // the last bit shifted out rounds half away from zero
                  for (int i = 0; i < 4; i++) begin
                     a_ff[i] <= mag_ff[i][30:0] + 31'(rbit_ff[i]);
                  end
                  sq_idx_ff <= 2'd0;
                  ph_ff     <= MPH_LO;
                  state_ff  <= S_SQ;
               end
            end
            S_SQ: begin
               unique case (ph_ff)
                  MPH_LO: begin
                     prod_ff <= mul_p[63:0];
                     ph_ff   <= MPH_HI;
                  end
                  MPH_HI: begin
                     acc_ff  <= acc_lo_sum;
                     prod_ff <= mul_p[63:0];
                     ph_ff   <= MPH_ADD;
                  end
                  default: begin
                     acc_ff    <= acc_hi_sum;
                     ph_ff     <= MPH_LO;
                     sq_idx_ff <= sq_idx_ff + 1'b1;
                     if (sq_idx_ff == 2'd3) begin
                        sr_x_ff   <= acc_hi_sum;
                        sr_r_ff   <= '0;
                        sr_bit_ff <= 64'd1 << 62;
                        state_ff  <= S_SQRT;
                     end
                  end
               endcase
            end
            S_SQRT: begin
               if (sq_ge) begin
                  sr_x_ff <= sr_x_ff - sq_t;
               end
               sr_r_ff   <= sq_r_next;
               sr_bit_ff <= sr_bit_ff >> 2;
               if (sr_bit_ff[0]) begin
                  n_ff       <= sq_r_next[31:0];
                  div_idx_ff <= 2'd0;
                  state_ff   <= S_DIVLD;
               end
            end
            S_DIVLD: begin
               rem_ff     <= RW'(div_num[NW-1:K]);
               nq_ff      <= div_num[K-1:0];
               div_cnt_ff <= '0;
               state_ff   <= S_DIV;
            end
            S_DIV: begin
               rem_ff     <= div_ge ? (div_trial - RW'(n_ff)) : div_trial;
               nq_ff      <= {nq_ff[K-2:0], div_ge};
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == KCW'(K - 1)) begin
                  state_ff <= S_DIVST;
               end
            end
            S_DIVST: begin
               q_ff[div_idx_ff] <= div_res;
               div_idx_ff       <= div_idx_ff + 1'b1;
               state_ff         <= (div_idx_ff == 2'd3) ? S_DONE : S_DIVLD;
            end
            S_DONE: begin
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tdata_ff  <= {q_ff[3], q_ff[2], q_ff[1], q_ff[0]};
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // an accepted beat always starts the program or goes straight to the result
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_PROG || state_ff == S_DONE))
      else $error("accepted beat did not start work");

   // a finished result waits while the response register is still full
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_tvalid_ff && !rsp_tready) |=> (state_ff == S_DONE))
      else $error("pending response overwritten");

   // after the normalizing shift every magnitude fits the squaring operands
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQ) |-> (a_ff[0] <= 31'h4000_0000 && a_ff[1] <= 31'h4000_0000 &&
                              a_ff[2] <= 31'h4000_0000 && a_ff[3] <= 31'h4000_0000))
      else $error("normalized magnitude out of range");

   // the square root walks exactly one bit pair at a time
   a_sqrt_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT) |-> $onehot(sr_bit_ff))
      else $error("square root bit lost");

   // the quotient never exceeds one plus rounding
   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVST && n_ff != '0) |-> (quot_x <= (32'd1 << QF) + 32'd1))
      else $error("quotient beyond unit length");

endmodule

// ----- sim/quaternion_attitude_update_unit_tb.sv -----
// testbench of the quaternion attitude update unit: directed and random beats against a predictor
`timescale 1ns / 1ps

module quaternion_attitude_update_unit_tb;
   import qau_pkg::*;

   localparam int QFB      = QAU_QUAT_FRAC_BITS;
   localparam int SFB      = QAU_STEP_FRAC_BITS;
   localparam int WDOG_MAX = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // step_roll, step_pitch, step_yaw, load_w, load_x, load_y, load_z
   logic [111:0] req_tdata = '0;
   // mode
   logic [0:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // quat_w, quat_x, quat_y, quat_z
   logic [63:0]  rsp_tdata;

   // predicted attitude and the queue of expected response beats
   logic signed [15:0] att_model [4];
   logic [63:0]        quat_expected [$];
   int                 error_count = 0;
   int                 wdog = 0;
   bit                 idling_on = 1'b1;
   int                 stall_left = 0;

   quaternion_attitude_update_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic longint unsigned magn(longint v);
      return v < 0 ? 64'd0 - longint'(v) : v;
   endfunction

   // shift right rounding half away from zero
   function automatic longint shift_round(longint v, int s);
      longint unsigned m;
      if (s == 0) return v;
      m = (magn(v) + (64'd1 << (s - 1))) >> s;
      return v < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // first-order attitude integration with renormalization
   task automatic integrate_steps(input logic signed [15:0] st [3]);
      longint q [4], wc [3], m [9], wg [3], acc [4], a [4], sum, v;
      longint unsigned maxm, sumsq, n, r;
      int s;
      for (int i = 0; i < 4; i++) q[i] = att_model[i];
      for (int i = 0; i < 3; i++)
         wc[i] = shift_round(longint'(st[i]) * longint'(D2R_Q30), SFB + 2);
      m[0] = q[0]*q[0] + q[1]*q[1] - q[2]*q[2] - q[3]*q[3];
      m[1] = 2 * (q[1]*q[2] - q[0]*q[3]);
      m[2] = 2 * (q[1]*q[3] + q[0]*q[2]);
      m[3] = 2 * (q[1]*q[2] + q[0]*q[3]);
      m[4] = q[0]*q[0] - q[1]*q[1] + q[2]*q[2] - q[3]*q[3];
      m[5] = 2 * (q[2]*q[3] - q[0]*q[1]);
      m[6] = 2 * (q[1]*q[3] - q[0]*q[2]);
      m[7] = 2 * (q[2]*q[3] + q[0]*q[1]);
      m[8] = q[0]*q[0] - q[1]*q[1] - q[2]*q[2] + q[3]*q[3];
      for (int i = 0; i < 3; i++) begin
         sum = 0;
         for (int j = 0; j < 3; j++) sum += shift_round(m[3*i+j], QFB) * wc[j];
         wg[i] = clip(shift_round(sum, QFB), -longint'(WG_LIMIT), longint'(WG_LIMIT));
      end
      acc[0] = q[0] * (64'sd1 <<< 29) - wg[0]*q[1] - wg[1]*q[2] - wg[2]*q[3];
      acc[1] = q[1] * (64'sd1 <<< 29) + wg[0]*q[0] - wg[2]*q[2] + wg[1]*q[3];
      acc[2] = q[2] * (64'sd1 <<< 29) + wg[1]*q[0] + wg[2]*q[1] - wg[0]*q[3];
      acc[3] = q[3] * (64'sd1 <<< 29) + wg[2]*q[0] - wg[1]*q[1] + wg[0]*q[2];
      maxm = 0;
      for (int i = 0; i < 4; i++) if (magn(acc[i]) > maxm) maxm = magn(acc[i]);
      s = 0;
      while ((maxm >> s) >= (64'd1 << 30)) s++;
      sumsq = 0;
      for (int i = 0; i < 4; i++) begin
         a[i] = shift_round(acc[i], s);
         sumsq += magn(a[i]) * magn(a[i]);
      end
      n = int_sqrt(sumsq);
      for (int i = 0; i < 4; i++) begin
         v = 0;
         // all-zero quaternion stays zero
         if (n != 0) begin
            r = ((magn(a[i]) << QFB) + (n >> 1)) / n;
            v = a[i] < 0 ? -longint'(r) : longint'(r);
         end
         att_model[i] = clip(v, -32768, 32767);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!idling_on || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 150);
   endfunction

   // drive one request beat, wait for acceptance, record the expected response
   task automatic send_beat(input bit mode, input logic signed [15:0] st [3],
                            input logic signed [15:0] ld [4]);
      int gap;
      req_tuser  = mode;
      req_tdata  = {ld[3], ld[2], ld[1], ld[0], st[2], st[1], st[0]};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      if (mode) begin
         for (int i = 0; i < 4; i++) att_model[i] = ld[i];
      end else begin
         integrate_steps(st);
      end
      quat_expected.push_back({att_model[3], att_model[2], att_model[1], att_model[0]});
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic rotate_by(input logic signed [15:0] r, input logic signed [15:0] p,
                            input logic signed [15:0] y);
      logic signed [15:0] st [3];
      logic signed [15:0] ld [4];
      st = '{r, p, y};
      ld = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      send_beat(1'b0, st, ld);
   endtask

   task automatic load_quat(input logic signed [15:0] w, input logic signed [15:0] x,
                            input logic signed [15:0] y, input logic signed [15:0] z);
      logic signed [15:0] st [3];
      logic signed [15:0] ld [4];
      st = '{16'($urandom), 16'($urandom), 16'($urandom)};
      ld = '{w, x, y, z};
      send_beat(1'b1, st, ld);
   endtask

   // rotation from the reset identity, then step extremes
   task automatic test_step_extremes();
      rotate_by(16'sd0, 16'sd0, 16'sd0);
      rotate_by(16'sd128, 16'sd0, 16'sd0);
      rotate_by(16'sd0, -16'sd128, 16'sd0);
      rotate_by(16'sd0, 16'sd0, 16'sd640);
      rotate_by(16'sh7fff, 16'sh7fff, 16'sh7fff);
      rotate_by(-16'sd32768, -16'sd32768, -16'sd32768);
      rotate_by(16'sh7fff, -16'sd32768, 16'sd1);
   endtask

   // loads are stored unchanged, including out-of-unit extremes, each followed by a rotation
   task automatic test_load_extremes();
      load_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      rotate_by(16'sd64, 16'sd64, -16'sd64);
      load_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
      rotate_by(-16'sd32768, 16'sh7fff, 16'sd0);
      load_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
      rotate_by(16'sd0, 16'sd0, 16'sd0);
      load_quat(16'sd0, 16'sd0, 16'sd0, -16'sd1);
      rotate_by(16'sd300, 16'sd0, 16'sd0);
      load_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
      rotate_by(16'sd1000, -16'sd2000, 16'sd3000);
   endtask

   // an all-zero quaternion stays all zero under rotation
   task automatic test_zero_quaternion();
      load_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
      rotate_by(16'sd0, 16'sd0, 16'sd0);
      rotate_by(16'sh7fff, -16'sd32768, 16'sd12345);
      load_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
   endtask

   task automatic test_random_walk(input int count);
      int k;
      for (int i = 0; i < count; i++) begin
         if (i % 150 == 0) idling_on = ($urandom_range(0, 3) != 0);
         k = $urandom_range(0, 99);
         if (k < 8) begin
            load_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         end else if (k < 20) begin
            // quaternion with w of up to unit magnitude and random sign, small x, y and z
            load_quat(16'($urandom_range(0, 16384) * ($urandom_range(0, 1) ? 1 : -1)),
                      16'($urandom_range(0, 9000) - 4500),
                      16'($urandom_range(0, 9000) - 4500),
                      16'($urandom_range(0, 9000) - 4500));
         end else if (k < 25) begin
            load_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
         end else if (k < 70) begin
            // small steps, the usual viewer case
            rotate_by(16'($urandom_range(0, 2000) - 1000),
                      16'($urandom_range(0, 2000) - 1000),
                      16'($urandom_range(0, 2000) - 1000));
         end else begin
            rotate_by(16'($urandom), 16'($urandom), 16'($urandom));
         end
      end
      idling_on = 1'b1;
   endtask

   // response side: random back-pressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pick_gap();
      end
   end

   // response check against the oldest expected beat
   always @(posedge clock) begin
      logic [63:0] exp_q;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (quat_expected.size() == 0) begin
            $error("response beat with nothing expected: %h", rsp_tdata);
            error_count++;
         end else begin
            exp_q = quat_expected.pop_front();
            if (rsp_tdata[15:0] !== exp_q[15:0]) begin
               $error("quat_w expected %0d actual %0d", $signed(exp_q[15:0]),
                      $signed(rsp_tdata[15:0]));
               error_count++;
            end
            if (rsp_tdata[31:16] !== exp_q[31:16]) begin
               $error("quat_x expected %0d actual %0d", $signed(exp_q[31:16]),
                      $signed(rsp_tdata[31:16]));
               error_count++;
            end
            if (rsp_tdata[47:32] !== exp_q[47:32]) begin
               $error("quat_y expected %0d actual %0d", $signed(exp_q[47:32]),
                      $signed(rsp_tdata[47:32]));
               error_count++;
            end
            if (rsp_tdata[63:48] !== exp_q[63:48]) begin
               $error("quat_z expected %0d actual %0d", $signed(exp_q[63:48]),
                      $signed(rsp_tdata[63:48]));
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         wdog <= 0;
      end else if (wdog >= WDOG_MAX) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         wdog <= wdog + 1;
      end
   end

   initial begin
      att_model = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_step_extremes();
      test_load_extremes();
      test_zero_quaternion();
      test_random_walk(1950);
      req_tvalid = 1'b0;
      while (quat_expected.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (error_count == 0 && quat_expected.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/qau_pkg.sv
rtl/quaternion_attitude_update_unit.sv
sim/quaternion_attitude_update_unit_tb.sv
